// File: sv/sfbc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfbc_pkg
// shared types, constants and helpers of the spi flash boot image copier
// ---------------------------------------------------------------------------
package sfbc_pkg;

    localparam int PAGE_BYTES    = 256;
    localparam int INT_ADDR_BITS = 17;
    localparam int PB_AW         = $clog2(PAGE_BYTES);
    localparam int WD_AW         = PB_AW - 1;
    localparam int BC_W          = $clog2(PAGE_BYTES + 5);

    localparam logic [7:0] CMD_READ    = 8'h03;
    localparam logic [7:0] CMD_PROG    = 8'h02;
    localparam logic [7:0] CMD_SECT_ER = 8'h20;
    localparam logic [7:0] CMD_WREN    = 8'h06;
    localparam logic [7:0] CMD_RSTEN   = 8'h66;
    localparam logic [7:0] CMD_RST     = 8'h99;
    localparam logic [7:0] CMD_RDSR    = 8'h05;
    localparam logic [7:0] CMD_JEDEC   = 8'h9F;

    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_SPI   = 2'd1;
    localparam logic [1:0] FN_INT   = 2'd2;

    localparam logic [1:0] OC_RUN    = 2'd0;
    localparam logic [1:0] OC_NOIMG  = 2'd1;
    localparam logic [1:0] OC_COPIED = 2'd2;
    localparam logic [1:0] OC_FAILED = 2'd3;

    localparam logic [1:0] OP_ERR_HI = 2'd0;
    localparam logic [1:0] OP_ERR_LO = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;

    localparam logic [2:0] CFG_ID     = 3'd0;
    localparam logic [2:0] CFG_MAGIC  = 3'd1;
    localparam logic [2:0] CFG_STATUS = 3'd2;
    localparam logic [2:0] CFG_SUMTAB = 3'd3;
    localparam logic [2:0] CFG_IMAGE  = 3'd4;
    localparam logic [2:0] CFG_ERROR  = 3'd5;
    localparam logic [2:0] CFG_APPEND = 3'd6;
    localparam logic [2:0] CFG_TRIES  = 3'd7;

    typedef enum logic [2:0] {
        ACT_SEND  = 3'd0,
        ACT_REL   = 3'd1,
        ACT_ERASE = 3'd2,
        ACT_FILL  = 3'd3,
        ACT_WRITE = 3'd4,
        ACT_DONE  = 3'd5
    } t_action;

    typedef struct packed {
        t_action                    action;
        logic [7:0]                 tx;
        logic [INT_ADDR_BITS-1:0]   addr;
        logic [1:0]                 outcome;
        logic                       last;
    } t_res;

    function automatic t_res mk_res(t_action a, logic [7:0] tx,
                                    logic [INT_ADDR_BITS-1:0] addr, logic [1:0] oc);
        t_res r;
        r.action  = a;
        r.tx      = tx;
        r.addr    = addr;
        r.outcome = oc;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] addr_cmd(logic [7:0] cmd, logic [23:0] addr,
                                            logic [BC_W-1:0] k);
        logic [7:0] b;
        case (k)
            BC_W'(0): b = cmd;
            BC_W'(1): b = addr[23:16];
            BC_W'(2): b = addr[15:8];
            BC_W'(3): b = addr[7:0];
            default:  b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/sfbc_page_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfbc_page_mem
// page buffer, byte writes, registered little-endian word reads
// ---------------------------------------------------------------------------
module sfbc_page_mem import sfbc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [PB_AW-1:0] i_waddr,
    input  logic [7:0]       i_wdata,
    input  logic             i_re,
    input  logic [WD_AW-1:0] i_raddr,
    output logic [15:0]      o_rdata
);

    logic [7:0] r_even [PAGE_BYTES/2];
    logic [7:0] r_odd  [PAGE_BYTES/2];
    logic [7:0] r_rd_even;
    logic [7:0] r_rd_odd;

    always_ff @(posedge i_clk) begin
        if (i_we && !i_waddr[0]) begin
            r_even[i_waddr[PB_AW-1:1]] <= i_wdata;
        end
        if (i_we && i_waddr[0]) begin
            r_odd[i_waddr[PB_AW-1:1]] <= i_wdata;
        end
        if (i_re) begin
            r_rd_even <= r_even[i_raddr];
            r_rd_odd  <= r_odd[i_raddr];
        end
    end

    assign o_rdata = {r_rd_odd, r_rd_even};

endmodule

// File: sv/sfbc_res_buf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfbc_res_buf
// holds the up to three requests of one item and hands them out in order
// ---------------------------------------------------------------------------
module sfbc_res_buf import sfbc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [1:0] i_load_cnt,
    input  t_res       i_load_res [3],
    input  logic       i_take,
    output logic [1:0] o_cnt,
    output t_res       o_head
);

    t_res       r_slot [3];
    logic [1:0] r_cnt;
    t_res       n_slot [3];
    logic [1:0] n_cnt;

    always_comb begin
        n_slot = r_slot;
        n_cnt  = r_cnt;
        if (i_take) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
            n_cnt     = r_cnt - 2'd1;
        end
        if (i_load) begin
            n_slot = i_load_res;
            n_cnt  = i_load_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt  = r_cnt;
    assign o_head = r_slot[0];

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3 || !$past(i_take)  || $past(i_load))
        else $error("request buffer overfilled");
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> r_cnt == 2'd0 || (r_cnt == 2'd1 && i_take))
        else $error("load over pending requests");
    a_head_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd1 |-> r_slot[0].last)
        else $error("final request not marked last");

endmodule

// File: sv/spi_flash_image_boot_copier_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spi_flash_image_boot_copier_core
// sequencer that copies a checked boot image from spi nor flash to internal
// program flash, with the page buffer held in a synchronous memory
// output: first request of an item shows in the cycle after it is accepted
// throughput: one item per cycle while it causes one request and i_stall is low; else the next
// item waits until the three-entry request buffer, draining one per unstalled cycle, takes its last
// reset: synchronous, active low; sequencer idle, registers to defaults
// ---------------------------------------------------------------------------
module spi_flash_image_boot_copier_core import sfbc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_func,
    input  logic [7:0]               i_rx_byte,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [2:0]               o_action,
    output logic [7:0]               o_tx_byte,
    output logic [INT_ADDR_BITS-1:0] o_page_addr,
    output logic [15:0]              o_fill_word,
    output logic [1:0]               o_outcome,
    output logic                     o_last,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [2:0]               i_cfg_index,
    input  logic [23:0]              i_cfg_data
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_INIT_POLL, PH_RSTEN, PH_RST, PH_ID, PH_RD_MAGIC, PH_RD_COUNT,
        PH_RD_PAGE, PH_RD_SUM, PH_ERASE_WAIT, PH_FILL_WAIT, PH_WRITE_WAIT,
        PH_OP_POLL_A, PH_OP_WREN, PH_OP_CMD, PH_OP_POLL_B, PH_DONE
    } t_phase;

    logic [23:0] r_exp_id, r_status, r_sumtab, r_image, r_error;
    logic [15:0] r_magic;
    logic [17:0] r_app_end;
    logic [2:0]  r_max_tries;

    t_phase                   r_phase, n_phase;
    logic [1:0]               r_op, n_op;
    logic [BC_W-1:0]          r_bc, n_bc;
    logic [23:0]              r_wc, n_wc;
    logic [15:0]              r_rs, n_rs, r_pn, n_pn, r_pt, n_pt;
    logic [23:0]              r_rp, n_rp, r_sp, n_sp;
    logic [INT_ADDR_BITS-1:0] r_ip, n_ip;
    logic [2:0]               r_try, n_try;

    t_res       w_res [3];
    logic [1:0] w_nres;
    logic       w_fill;
    logic       w_we;
    logic [PB_AW-1:0] w_waddr;
    logic       w_accept;
    logic       w_take;
    logic [1:0] w_cnt;
    t_res       w_head;
    logic [15:0] w_rdata;
    logic       r_head_fill;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = w_cnt != 2'd0;
    assign w_take      = o_valid && !i_stall;
    assign o_stall     = !(w_cnt == 2'd0 || (w_cnt == 2'd1 && w_take));
    assign w_accept    = i_valid && !o_stall;

    always_comb begin
        logic [1:0]  k;
        logic [7:0]  cmd;
        logic [23:0] addr;
        logic [7:0]  data;
        logic [2:0]  lim;
        logic [BC_W-1:0] bc1;
        logic [BC_W-1:0] pidx;
        k = 2'd0;
        n_phase = r_phase; n_op = r_op; n_bc = r_bc; n_wc = r_wc; n_rs = r_rs;
        n_pn = r_pn; n_pt = r_pt; n_rp = r_rp; n_sp = r_sp; n_ip = r_ip;
        n_try = r_try;
        w_fill = 1'b0; w_we = 1'b0; w_waddr = '0;
        for (int j = 0; j < 3; j++) begin
            w_res[j] = mk_res(ACT_SEND, 8'h00, '0, OC_RUN);
        end
        bc1  = r_bc + BC_W'(1);
        pidx = r_bc - BC_W'(4);
        cmd  = (r_op == OP_ERASE) ? CMD_SECT_ER : CMD_PROG;
        addr = (r_op == OP_ERASE) ? r_status : r_error;
        data = (r_op == OP_ERR_HI) ? r_pn[15:8] : r_pn[7:0];
        lim  = (r_max_tries == 3'd0) ? 3'd1 : r_max_tries;
        if (i_func == FN_START) begin
            n_pn = '0; n_pt = '0; n_rs = '0; n_try = '0; n_wc = '0; n_ip = '0;
            n_rp = r_image; n_sp = r_sumtab; n_phase = PH_INIT_POLL; n_bc = '0;
            w_res[k] = mk_res(ACT_SEND, CMD_RDSR, '0, OC_RUN); k = k + 2'd1;
        end else if (i_func == FN_SPI) begin
            case (r_phase)
                PH_INIT_POLL, PH_OP_POLL_A, PH_OP_POLL_B: begin
                    if (r_bc == '0) begin
                        n_bc = BC_W'(1);
                        w_res[k] = mk_res(ACT_SEND, 8'h00, '0, OC_RUN); k = k + 2'd1;
                    end else if (i_rx_byte[0]) begin
                        w_res[k] = mk_res(ACT_SEND, 8'h00, '0, OC_RUN); k = k + 2'd1;
                    end else begin
                        w_res[k] = mk_res(ACT_REL, 8'h00, '0, OC_RUN); k = k + 2'd1;
                        if (r_phase == PH_INIT_POLL) begin
                            n_phase = PH_RSTEN;
                            w_res[k] = mk_res(ACT_SEND, CMD_RSTEN, '0, OC_RUN);
                            k = k + 2'd1;
                        end else if (r_phase == PH_OP_POLL_A) begin
                            n_phase = PH_OP_WREN;
                            w_res[k] = mk_res(ACT_SEND, CMD_WREN, '0, OC_RUN);
                            k = k + 2'd1;
                        end else if (r_op != OP_ERASE) begin
                            n_phase = PH_OP_POLL_A; n_op = r_op + 2'd1; n_bc = '0;
                            w_res[k] = mk_res(ACT_SEND, CMD_RDSR, '0, OC_RUN);
                            k = k + 2'd1;
                        end else begin
                            n_phase = PH_DONE;
                            w_res[k] = mk_res(ACT_DONE, 8'h00, '0,
                                              (r_pn < r_pt) ? OC_FAILED : OC_COPIED);
                            k = k + 2'd1;
                        end
                    end
                end
                PH_OP_WREN: begin
                    n_phase = PH_OP_CMD; n_bc = '0;
                    w_res[k] = mk_res(ACT_REL, 8'h00, '0, OC_RUN); k = k + 2'd1;
                    w_res[k] = mk_res(ACT_SEND, cmd, '0, OC_RUN); k = k + 2'd1;
                end
                PH_OP_CMD: begin
                    n_bc = bc1;
                    if (bc1 < ((r_op == OP_ERASE) ? BC_W'(4) : BC_W'(5))) begin
                        w_res[k] = mk_res(ACT_SEND, (bc1 == BC_W'(4)) ? data :
                                          addr_cmd(cmd, addr, bc1), '0, OC_RUN);
                        k = k + 2'd1;
                    end else begin
                        n_phase = PH_OP_POLL_B; n_bc = '0;
                        w_res[k] = mk_res(ACT_REL, 8'h00, '0, OC_RUN); k = k + 2'd1;
                        w_res[k] = mk_res(ACT_SEND, CMD_RDSR, '0, OC_RUN); k = k + 2'd1;
                    end
                end
                PH_RSTEN: begin
                    n_phase = PH_RST;
                    w_res[k] = mk_res(ACT_REL, 8'h00, '0, OC_RUN); k = k + 2'd1;
                    w_res[k] = mk_res(ACT_SEND, CMD_RST, '0, OC_RUN); k = k + 2'd1;
                end
                PH_RST: begin
                    n_phase = PH_ID; n_bc = '0; n_wc = '0;
                    w_res[k] = mk_res(ACT_REL, 8'h00, '0, OC_RUN); k = k + 2'd1;
                    w_res[k] = mk_res(ACT_SEND, CMD_JEDEC, '0, OC_RUN); k = k + 2'd1;
                end
                PH_ID: begin
                    if (r_bc >= BC_W'(1)) begin
                        n_wc = {r_wc[15:0], i_rx_byte};
                    end
                    n_bc = bc1;
                    if (bc1 < BC_W'(4)) begin
                        w_res[k] = mk_res(ACT_SEND, 8'h00, '0, OC_RUN); k = k + 2'd1;
                    end else begin
                        w_res[k] = mk_res(ACT_REL, 8'h00, '0, OC_RUN); k = k + 2'd1;
                        if (n_wc == r_exp_id) begin
                            n_phase = PH_RD_MAGIC; n_bc = '0; n_wc = '0;
                            w_res[k] = mk_res(ACT_SEND, CMD_READ, '0, OC_RUN);
                            k = k + 2'd1;
                        end else begin
                            n_phase = PH_DONE;
                            w_res[k] = mk_res(ACT_DONE, 8'h00, '0, OC_NOIMG);
                            k = k + 2'd1;
                        end
                    end
                end
                PH_RD_MAGIC, PH_RD_COUNT, PH_RD_SUM: begin
                    if (r_phase == PH_RD_MAGIC) begin
                        addr = r_status;
                    end else if (r_phase == PH_RD_COUNT) begin
                        addr = r_status + 24'd2;
                    end else begin
                        addr = r_sp;
                    end
                    if (r_bc >= BC_W'(4)) begin
                        n_wc = {8'h00, r_wc[7:0], i_rx_byte};
                    end
                    n_bc = bc1;
                    if (bc1 < BC_W'(6)) begin
                        w_res[k] = mk_res(ACT_SEND, addr_cmd(CMD_READ, addr, bc1), '0,
                                          OC_RUN);
                        k = k + 2'd1;
                    end else begin
                        w_res[k] = mk_res(ACT_REL, 8'h00, '0, OC_RUN); k = k + 2'd1;
                        if (r_phase == PH_RD_MAGIC) begin
                            if (n_wc[15:0] == r_magic) begin
                                n_phase = PH_RD_COUNT; n_bc = '0; n_wc = '0;
                                w_res[k] = mk_res(ACT_SEND, CMD_READ, '0, OC_RUN);
                                k = k + 2'd1;
                            end else begin
                                n_phase = PH_DONE;
                                w_res[k] = mk_res(ACT_DONE, 8'h00, '0, OC_NOIMG);
                                k = k + 2'd1;
                            end
                        end else if (r_phase == PH_RD_COUNT) begin
                            n_pt = n_wc[15:0];
                            if (n_wc[15:0] == 16'd0) begin
                                n_phase = PH_OP_POLL_A; n_op = OP_ERASE; n_bc = '0;
                                w_res[k] = mk_res(ACT_SEND, CMD_RDSR, '0, OC_RUN);
                            end else begin
                                n_phase = PH_RD_PAGE; n_rs = '0; n_bc = '0;
                                w_res[k] = mk_res(ACT_SEND, CMD_READ, '0, OC_RUN);
                            end
                            k = k + 2'd1;
                        end else if (n_wc[15:0] == r_rs) begin
                            if ({1'b0, r_ip} < r_app_end) begin
                                n_phase = PH_ERASE_WAIT;
                                w_res[k] = mk_res(ACT_ERASE, 8'h00, r_ip, OC_RUN);
                            end else begin
                                n_phase = PH_FILL_WAIT; n_bc = '0; w_fill = 1'b1;
                                w_res[k] = mk_res(ACT_FILL, 8'h00, r_ip, OC_RUN);
                            end
                            k = k + 2'd1;
                        end else begin
                            n_try = r_try + 3'd1;
                            n_bc  = '0;
                            if (n_try >= lim) begin
                                n_phase = PH_OP_POLL_A; n_op = OP_ERR_HI;
                                w_res[k] = mk_res(ACT_SEND, CMD_RDSR, '0, OC_RUN);
                            end else begin
                                n_phase = PH_RD_PAGE; n_rs = '0;
                                w_res[k] = mk_res(ACT_SEND, CMD_READ, '0, OC_RUN);
                            end
                            k = k + 2'd1;
                        end
                    end
                end
                PH_RD_PAGE: begin
                    if (r_bc >= BC_W'(4) && pidx < BC_W'(PAGE_BYTES)) begin
                        w_we    = 1'b1;
                        w_waddr = pidx[PB_AW-1:0];
                        n_rs    = r_rs + {8'h00, i_rx_byte};
                    end
                    n_bc = bc1;
                    if (bc1 < BC_W'(PAGE_BYTES + 4)) begin
                        w_res[k] = mk_res(ACT_SEND, addr_cmd(CMD_READ, r_rp, bc1), '0,
                                          OC_RUN);
                        k = k + 2'd1;
                    end else begin
                        n_phase = PH_RD_SUM; n_bc = '0; n_wc = '0;
                        w_res[k] = mk_res(ACT_REL, 8'h00, '0, OC_RUN); k = k + 2'd1;
                        w_res[k] = mk_res(ACT_SEND, CMD_READ, '0, OC_RUN); k = k + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_func == FN_INT) begin
            case (r_phase)
                PH_ERASE_WAIT: begin
                    n_phase = PH_FILL_WAIT; n_bc = '0; w_fill = 1'b1;
                    w_res[k] = mk_res(ACT_FILL, 8'h00, r_ip, OC_RUN); k = k + 2'd1;
                end
                PH_FILL_WAIT: begin
                    n_bc = bc1;
                    if (bc1 < BC_W'(PAGE_BYTES / 2)) begin
                        w_fill = 1'b1;
                        w_res[k] = mk_res(ACT_FILL, 8'h00,
                                          r_ip + INT_ADDR_BITS'({bc1, 1'b0}), OC_RUN);
                    end else begin
                        n_phase = PH_WRITE_WAIT;
                        w_res[k] = mk_res(ACT_WRITE, 8'h00, r_ip, OC_RUN);
                    end
                    k = k + 2'd1;
                end
                PH_WRITE_WAIT: begin
                    n_rp  = r_rp + 24'(PAGE_BYTES);
                    n_sp  = r_sp + 24'd2;
                    n_ip  = r_ip + INT_ADDR_BITS'(PAGE_BYTES);
                    n_pn  = r_pn + 16'd1;
                    n_try = '0;
                    n_bc  = '0;
                    if (n_pn < r_pt) begin
                        n_phase = PH_RD_PAGE; n_rs = '0;
                        w_res[k] = mk_res(ACT_SEND, CMD_READ, '0, OC_RUN);
                    end else begin
                        n_phase = PH_OP_POLL_A; n_op = OP_ERASE;
                        w_res[k] = mk_res(ACT_SEND, CMD_RDSR, '0, OC_RUN);
                    end
                    k = k + 2'd1;
                end
                default: begin
                end
            endcase
        end
        w_nres = k;
        if (k != 2'd0) begin
            w_res[k - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_id <= 24'hEF4017; r_magic <= 16'h2323; r_status <= 24'd4096;
            r_sumtab <= 24'd4352; r_image <= 24'd8192; r_error <= 24'd256;
            r_app_end <= 18'd114688; r_max_tries <= 3'd3;
            r_phase <= PH_IDLE; r_op <= OP_ERR_HI; r_bc <= '0; r_wc <= '0;
            r_rs <= '0; r_pn <= '0; r_pt <= '0; r_rp <= '0; r_sp <= '0;
            r_ip <= '0; r_try <= '0; r_head_fill <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ID:     r_exp_id    <= i_cfg_data;
                    CFG_MAGIC:  r_magic     <= i_cfg_data[15:0];
                    CFG_STATUS: r_status    <= i_cfg_data;
                    CFG_SUMTAB: r_sumtab    <= i_cfg_data;
                    CFG_IMAGE:  r_image     <= i_cfg_data;
                    CFG_ERROR:  r_error     <= i_cfg_data;
                    CFG_APPEND: r_app_end   <= i_cfg_data[17:0];
                    CFG_TRIES:  r_max_tries <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_phase <= n_phase; r_op <= n_op; r_bc <= n_bc; r_wc <= n_wc;
                r_rs <= n_rs; r_pn <= n_pn; r_pt <= n_pt; r_rp <= n_rp;
                r_sp <= n_sp; r_ip <= n_ip; r_try <= n_try;
                r_head_fill <= w_fill;
            end
        end
    end

    sfbc_page_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (w_accept && w_fill),
        .i_raddr (n_bc[WD_AW-1:0]),
        .o_rdata (w_rdata)
    );

    sfbc_res_buf u_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_load_cnt (w_nres),
        .i_load_res (w_res),
        .i_take     (w_take),
        .o_cnt      (w_cnt),
        .o_head     (w_head)
    );

    assign o_action    = w_head.action;
    assign o_tx_byte   = w_head.tx;
    assign o_page_addr = w_head.addr;
    assign o_outcome   = w_head.outcome;
    assign o_last      = w_head.last;
    assign o_fill_word = (w_head.action == ACT_FILL && r_head_fill) ? w_rdata : 16'h0000;

    a_fill_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == ACT_FILL |-> r_phase == PH_FILL_WAIT)
        else $error("fill request outside fill phase");
    a_we_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_we |-> r_phase == PH_RD_PAGE && i_func == FN_SPI)
        else $error("page buffer written outside page read");
    a_done_oc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == ACT_DONE |-> o_outcome != OC_RUN && r_phase == PH_DONE)
        else $error("finish without outcome");

endmodule
